// ===== rtl/bpc_pkg.sv =====
// ============================================================================
// bpc_pkg
// Shared types and constants for the barometric pressure/temperature
// compensation block.
// ============================================================================
package bpc_pkg;

    localparam int AddrW  = 5;
    localparam int DataW  = 32;
    localparam int CoeffW = 16;
    localparam int RawW   = 24;
    localparam int TempW  = 19;
    localparam int PressW = 32;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_SENS        = 3'd0;
    localparam logic [2:0] REG_OFFSET      = 3'd1;
    localparam logic [2:0] REG_SENS_TEMP   = 3'd2;
    localparam logic [2:0] REG_OFFSET_TEMP = 3'd3;
    localparam logic [2:0] REG_REF_TEMP    = 3'd4;
    localparam logic [2:0] REG_TEMP_COEFF  = 3'd5;

    localparam logic signed [19:0] TempBase = 20'sd2000;
    localparam logic signed [19:0] TempMax  = 20'sd140000;
    localparam logic signed [19:0] TempMin  = -20'sd140000;
    localparam logic signed [33:0] PressMax = 34'sd2147483647;
    localparam logic signed [33:0] PressMin = -34'sd2147483648;

    typedef struct packed {
        logic [CoeffW-1:0] sens_coeff;
        logic [CoeffW-1:0] offset_coeff;
        logic [CoeffW-1:0] sens_temp_coeff;
        logic [CoeffW-1:0] offset_temp_coeff;
        logic [CoeffW-1:0] ref_temp;
        logic [CoeffW-1:0] temp_coeff;
    } bpc_coeff_t;

    typedef struct packed {
        logic [RawW-1:0] raw_pressure;
        logic [RawW-1:0] raw_temperature;
    } bpc_in_t;

    typedef struct packed {
        logic signed [TempW-1:0]  temperature;
        logic signed [PressW-1:0] pressure;
        logic                     clipped;
    } bpc_out_t;

    // handoff between the coefficient stages and the pressure stages
    typedef struct packed {
        logic               valid;
        logic [RawW-1:0]    d1;
        logic signed [19:0] temp;
        logic signed [36:0] off;
        logic signed [35:0] sens;
    } bpc_mid_t;

endpackage

// ===== rtl/bpc_regs.sv =====
// ============================================================================
// bpc_regs
// APB register file holding the six calibration words.
// ============================================================================
module bpc_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bpc_pkg::AddrW-1:0] paddr,
    input  logic [bpc_pkg::DataW-1:0] pwdata,
    output logic [bpc_pkg::DataW-1:0] prdata,
    output logic                      pready,
    output bpc_pkg::bpc_coeff_t       coeff
);
    import bpc_pkg::*;

    bpc_coeff_t  coeff_reg;
    bpc_coeff_t  coeff_next;
    logic [2:0]  index;
    logic        wr_en;

    assign index  = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign coeff  = coeff_reg;

    always_comb
    begin
        coeff_next = coeff_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_SENS:        coeff_next.sens_coeff        = pwdata[CoeffW-1:0];
                REG_OFFSET:      coeff_next.offset_coeff      = pwdata[CoeffW-1:0];
                REG_SENS_TEMP:   coeff_next.sens_temp_coeff   = pwdata[CoeffW-1:0];
                REG_OFFSET_TEMP: coeff_next.offset_temp_coeff = pwdata[CoeffW-1:0];
                REG_REF_TEMP:    coeff_next.ref_temp          = pwdata[CoeffW-1:0];
                REG_TEMP_COEFF:  coeff_next.temp_coeff        = pwdata[CoeffW-1:0];
                default:         coeff_next = coeff_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_SENS:        prdata = DataW'(coeff_reg.sens_coeff);
            REG_OFFSET:      prdata = DataW'(coeff_reg.offset_coeff);
            REG_SENS_TEMP:   prdata = DataW'(coeff_reg.sens_temp_coeff);
            REG_OFFSET_TEMP: prdata = DataW'(coeff_reg.offset_temp_coeff);
            REG_REF_TEMP:    prdata = DataW'(coeff_reg.ref_temp);
            REG_TEMP_COEFF:  prdata = DataW'(coeff_reg.temp_coeff);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else
        begin
            coeff_reg <= coeff_next;
        end
    end

endmodule

// ===== rtl/bpc_coeff.sv =====
// ============================================================================
// bpc_coeff
// Stages 1-3: temperature difference, the three coefficient products,
// then temperature, offset and sensitivity.
// ============================================================================
module bpc_coeff (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  bpc_pkg::bpc_in_t    sample,
    input  bpc_pkg::bpc_coeff_t coeff,
    output bpc_pkg::bpc_mid_t   mid
);
    import bpc_pkg::*;

    // stage 1
    logic               v1_reg;
    logic [RawW-1:0]    d1_1_reg;
    logic signed [24:0] dt_reg;
    logic signed [24:0] dt_next;
    // stage 2
    logic               v2_reg;
    logic [RawW-1:0]    d1_2_reg;
    logic signed [41:0] p6_reg, p4_reg, p3_reg;
    logic signed [41:0] p6_next, p4_next, p3_next;
    // stage 3
    logic               v3_reg;
    logic [RawW-1:0]    d1_3_reg;
    logic signed [19:0] temp_reg, temp_next;
    logic signed [36:0] off_reg, off_next;
    logic signed [35:0] sens_reg, sens_next;

    assign dt_next = $signed({1'b0, sample.raw_temperature})
                   - $signed({1'b0, coeff.ref_temp, 8'b0});

    assign p6_next = dt_reg * $signed({1'b0, coeff.temp_coeff});
    assign p4_next = dt_reg * $signed({1'b0, coeff.offset_temp_coeff});
    assign p3_next = dt_reg * $signed({1'b0, coeff.sens_temp_coeff});

    // arithmetic right shifts give floor division
    assign temp_next = 20'($signed(p6_reg[41:23])) + TempBase;
    assign off_next  = $signed({4'b0, coeff.offset_coeff, 17'b0})
                     + 37'($signed(p4_reg[41:6]));
    assign sens_next = $signed({4'b0, coeff.sens_coeff, 16'b0})
                     + 36'($signed(p3_reg[41:7]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_1_reg <= sample.raw_pressure;
        dt_reg   <= dt_next;
        d1_2_reg <= d1_1_reg;
        p6_reg   <= p6_next;
        p4_reg   <= p4_next;
        p3_reg   <= p3_next;
        d1_3_reg <= d1_2_reg;
        temp_reg <= temp_next;
        off_reg  <= off_next;
        sens_reg <= sens_next;
    end

    assign mid.valid = v3_reg;
    assign mid.d1    = d1_3_reg;
    assign mid.temp  = temp_reg;
    assign mid.off   = off_reg;
    assign mid.sens  = sens_reg;

endmodule

// ===== rtl/bpc_press.sv =====
// ============================================================================
// bpc_press
// Stages 4-7: temperature clamp and split pressure product, recombine and
// scale, subtract offset, final scale and saturation into the result register.
// ============================================================================
module bpc_press (
    input  logic                clk,
    input  logic                rst_n,
    input  bpc_pkg::bpc_mid_t   mid,
    output logic                done,
    output bpc_pkg::bpc_out_t   result
);
    import bpc_pkg::*;

    // stage 4
    logic                     v4_reg;
    logic signed [TempW-1:0]  t4_reg, t4_next;
    logic                     tclip4_reg, tclip4_next;
    logic [41:0]              pplo_reg, pplo_next;
    logic signed [42:0]       pphi_reg, pphi_next;
    logic signed [36:0]       off4_reg;
    // stage 5
    logic                     v5_reg;
    logic signed [TempW-1:0]  t5_reg;
    logic                     tclip5_reg;
    logic signed [36:0]       off5_reg;
    logic signed [60:0]       full;
    logic signed [39:0]       q5_reg, q5_next;
    // stage 6
    logic                     v6_reg;
    logic signed [TempW-1:0]  t6_reg;
    logic                     tclip6_reg;
    logic signed [40:0]       diff6_reg, diff6_next;
    // stage 7
    logic                     done_reg;
    bpc_out_t                 out_reg, out_next;
    logic signed [33:0]       p_ext;
    logic                     p_hi, p_lo;

    always_comb
    begin
        tclip4_next = 1'b0;
        t4_next     = mid.temp[TempW-1:0];
        priority if (mid.temp > TempMax)
        begin
            t4_next     = TempMax[TempW-1:0];
            tclip4_next = 1'b1;
        end
        else if (mid.temp < TempMin)
        begin
            t4_next     = TempMin[TempW-1:0];
            tclip4_next = 1'b1;
        end
    end

    // sensitivity split into an unsigned low half and a signed high half
    assign pplo_next = mid.d1 * mid.sens[17:0];
    assign pphi_next = $signed({1'b0, mid.d1}) * $signed(mid.sens[35:18]);

    assign full    = $signed({pphi_reg, 18'b0}) + $signed({19'b0, pplo_reg});
    assign q5_next = full[60:21];

    assign diff6_next = 41'(q5_reg) - 41'(off5_reg);

    assign p_ext = 34'($signed(diff6_reg[40:15]));
    assign p_hi  = p_ext > PressMax;
    assign p_lo  = p_ext < PressMin;

    always_comb
    begin
        out_next.temperature = t6_reg;
        out_next.clipped     = tclip6_reg | p_hi | p_lo;
        priority if (p_hi)
        begin
            out_next.pressure = PressMax[PressW-1:0];
        end
        else if (p_lo)
        begin
            out_next.pressure = PressMin[PressW-1:0];
        end
        else
        begin
            out_next.pressure = p_ext[PressW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v4_reg   <= mid.valid;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            done_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t4_reg     <= t4_next;
        tclip4_reg <= tclip4_next;
        pplo_reg   <= pplo_next;
        pphi_reg   <= pphi_next;
        off4_reg   <= mid.off;
        t5_reg     <= t4_reg;
        tclip5_reg <= tclip4_reg;
        off5_reg   <= off4_reg;
        q5_reg     <= q5_next;
        t6_reg     <= t5_reg;
        tclip6_reg <= tclip5_reg;
        diff6_reg  <= diff6_next;
        out_reg    <= out_next;
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule

// ===== rtl/baro_pressure_temp_compensation.sv =====
// ============================================================================
// baro_pressure_temp_compensation
// First-order pressure/temperature compensation of raw 24-bit samples.
// ============================================================================
// Start travels with each sample through the valid registers of stages 1-7 to done.
// Throughput: one item per cycle; busy is always low, seven-stage pipeline.
// Reset clears the calibration words and all pipeline valid bits.
// Results come out on a one-cycle done strobe; the receiver cannot stall.
module baro_pressure_temp_compensation (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bpc_pkg::bpc_in_t          sample,
    output logic                      done,
    output bpc_pkg::bpc_out_t         result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bpc_pkg::AddrW-1:0] paddr,
    input  logic [bpc_pkg::DataW-1:0] pwdata,
    output logic [bpc_pkg::DataW-1:0] prdata,
    output logic                      pready
);
    import bpc_pkg::*;

    bpc_coeff_t coeff;
    bpc_mid_t   mid;

    assign busy = 1'b0;

    bpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coeff   (coeff)
    );

    bpc_coeff u_coeff (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .sample   (sample),
        .coeff    (coeff),
        .mid      (mid)
    );

    bpc_press u_press (
        .clk    (clk),
        .rst_n  (rst_n),
        .mid    (mid),
        .done   (done),
        .result (result)
    );

endmodule
